// ===== hdl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window maximum core
// Holds the controller state type, the command and status bundles between
// the controller and the datapath, and the register map constants.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Default sizing of the core.
    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Positions within a line count modulo 2^POS_W.
    localparam int POS_W  = 14;

    // Window length register.
    localparam int WLEN_W = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd1;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE
    } swm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input beat and advance the line position, or reseed on a line start
        logic pop;     // drop the head entry of the deque
        logic insert;  // trim the tail, append the sample and load the result
    } swm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_expired;  // head entry has left the window
        logic out_free;      // result register can take a new result
    } swm_status_t;

endpackage

// ===== hdl/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl: sequencing controller of the sliding window maximum core
// Accepts one input beat, then drops expired head entries one per cycle and
// finally commands the insert once the result register is free.
// ----------------------------------------------------------------------------
module swm_ctrl
    import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
);

    swm_state_t state_reg;
    swm_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.head_expired)
                begin
                    cmd.pop = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The datapath gets at most one command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.pop, cmd.insert}))
        else $error("swm_ctrl: more than one datapath command in a cycle");

endmodule

// ===== hdl/swm_dpath.sv =====
// ----------------------------------------------------------------------------
// swm_dpath: deque cells and result register of the sliding window maximum
// A row of cells holds the deque with its head in cell 0. Every cell compares
// its value with the new sample in parallel, so the tail trim and the append
// happen together in a single insert; a head pop shifts the row by one cell.
// ----------------------------------------------------------------------------
module swm_dpath
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_cmd_t               cmd,
    output swm_status_t            status,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   line_start,
    input  logic [WLEN_W-1:0]      window_len,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_BITS-1:0] window_max,
    output logic                   window_full
);

    localparam int DEPTH = WINDOW_MAX + 1;

    // Deque cells.
    logic [SAMPLE_BITS-1:0] val_reg  [DEPTH];
    logic [SAMPLE_BITS-1:0] val_next [DEPTH];
    logic [POS_W-1:0]       posn_reg [DEPTH];
    logic [POS_W-1:0]       posn_next[DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;

    // Line and item state.
    logic [POS_W-1:0]       line_pos_reg;
    logic [POS_W-1:0]       line_pos_next;
    logic                   filled_reg;
    logic                   filled_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;

    // Result register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SAMPLE_BITS-1:0] out_max_reg;
    logic [SAMPLE_BITS-1:0] out_max_next;
    logic                   out_full_reg;
    logic                   out_full_next;

    logic [POS_W-1:0]       win_k;
    logic [POS_W-1:0]       head_age;
    logic [DEPTH-1:0]       keep;
    logic [DEPTH-1:0]       place;

    // Effective window length: zero acts as one, and the length saturates
    // at the number of cells the window can span.
    always_comb
    begin
        if (window_len == '0)
        begin
            win_k = POS_W'(1);
        end
        else if (POS_W'(window_len) > POS_W'(WINDOW_MAX))
        begin
            win_k = POS_W'(WINDOW_MAX);
        end
        else
        begin
            win_k = POS_W'(window_len);
        end
    end

    // Head expiry and result register status.
    assign head_age            = line_pos_reg - posn_reg[0];
    assign status.head_expired = valid_reg[0] && (head_age >= win_k);
    assign status.out_free     = !out_valid_reg || m_tready;

    // Per-cell tail trim: a cell survives if its value beats the sample, and
    // the sample lands in the first cell that does not survive.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            keep[i] = valid_reg[i] && (val_reg[i] > sample_reg);
        end
        place[0] = !keep[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            place[i] = !keep[i] && keep[i-1];
        end
    end

    // Next state of cells, line state and result register.
    always_comb
    begin
        val_next       = val_reg;
        posn_next      = posn_reg;
        valid_next     = valid_reg;
        line_pos_next  = line_pos_reg;
        filled_next    = filled_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_max_next   = out_max_reg;
        out_full_next  = out_full_reg;

        if (cmd.load)
        begin
            sample_next = sample;
            if (line_start)
            begin
                // New line: seed the deque with an implicit zero at position 0.
                valid_next    = '0;
                valid_next[0] = 1'b1;
                val_next[0]   = '0;
                posn_next[0]  = '0;
                line_pos_next = POS_W'(1);
                filled_next   = 1'b0;
            end
            else
            begin
                line_pos_next = line_pos_reg + POS_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            // Shift the row one cell toward the head.
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                val_next[i]   = val_reg[i+1];
                posn_next[i]  = posn_reg[i+1];
                valid_next[i] = valid_reg[i+1];
            end
            valid_next[DEPTH-1] = 1'b0;
        end
        else if (cmd.insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_next[i] = keep[i] || place[i];
                if (place[i])
                begin
                    val_next[i]  = sample_reg;
                    posn_next[i] = line_pos_reg;
                end
            end
            filled_next    = filled_reg || (line_pos_reg >= win_k);
            out_valid_next = 1'b1;
            out_max_next   = keep[0] ? val_reg[0] : sample_reg;
            out_full_next  = filled_reg || (line_pos_reg >= win_k);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            line_pos_reg  <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            line_pos_reg  <= line_pos_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        posn_reg     <= posn_next;
        sample_reg   <= sample_next;
        out_max_reg  <= out_max_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign window_max  = out_max_reg;
    assign window_full = out_full_reg;

    // Occupied cells always form an unbroken run starting at the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg & (valid_reg + DEPTH'(1))) == '0)
        else $error("swm_dpath: deque cells are not contiguous from the head");

    // An insert never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> status.out_free)
        else $error("swm_dpath: insert while the result register is held");

    // A line start leaves only the implicit zero in the deque.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && line_start) |=> (valid_reg == DEPTH'(1)) && !filled_reg)
        else $error("swm_dpath: line start did not reseed the deque");

endmodule

// ===== hdl/sliding_window_maximum_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_core: streaming maximum over a sliding window
// Top level with the stream ports, the configuration register and the
// controller and datapath of the deque.
// ----------------------------------------------------------------------------
// Each sample beat yields one result beat holding the maximum of the last
// window_len samples of the current line (with an implicit zero leading the
// line) and a flag that the window has filled. Each item runs through these
// steps in order: accept the beat, pop the head of the deque cell row once
// for every head entry that leaves the window on that sample, then do the
// parallel tail trim and append. The append also waits for as long as an
// earlier result is still held in the output register. In steady state at
// most one head leaves per sample. A new beat is accepted while the previous
// result still waits in the output register. window_len lives at byte
// address 0; the user must write it only while the core is idle, and the
// core itself does not enforce this.
// ----------------------------------------------------------------------------
module sliding_window_maximum_core
    import swm_pkg::*;
#(
    parameter  int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                  s_tuser,   // [0] line_start
    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] window_max
    output logic                  m_tuser,   // [0] window_full
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [WLEN_W-1:0]      window_len_reg;
    logic [WLEN_W-1:0]      window_len_next;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   reg_write;
    swm_cmd_t               cmd;
    swm_status_t            status;
    logic [SAMPLE_BITS-1:0] window_max;

    // Register decode: word index from the byte address.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        window_len_next = window_len_reg;
        if (reg_write && (reg_idx == REG_WINDOW_LEN))
        begin
            window_len_next = pwdata[WLEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WLEN_RESET;
        end
        else
        begin
            window_len_reg <= window_len_next;
        end
    end

    // Register readback.
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_WINDOW_LEN)
        begin
            prdata = APB_DATA_W'(window_len_reg);
        end
    end

    // Controller.
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    swm_dpath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .sample      (s_tdata[SAMPLE_BITS-1:0]),
        .line_start  (s_tuser),
        .window_len  (window_len_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .window_max  (window_max),
        .window_full (m_tuser)
    );

    // Result data, zero filled to whole bytes.
    assign m_tdata = TDATA_W'(window_max);

endmodule
